// File: rtl/dmbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmbf_pkg
// Shared types, codes and helpers for the display mode best-fit search block.
// ----------------------------------------------------------------------------
package dmbf_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE    = 2'd0,
        CMD_VALIDATE = 2'd1,
        CMD_FIND     = 2'd2,
        CMD_BEST     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    localparam logic [1:0] CFG_ENTRY_COUNT = 2'd0;
    localparam logic [1:0] CFG_MAX_PCLK    = 2'd1;

    localparam logic [32:0] ROUND_BYTE  = 33'd7;
    localparam logic [30:0] ROUND_ALIGN = 31'd63;
    localparam logic [30:0] PITCH_LIMIT = 31'h0000_FFFF;

    localparam logic [15:0] BPP_8  = 16'd8;
    localparam logic [15:0] BPP_16 = 16'd16;
    localparam logic [15:0] BPP_24 = 16'd24;
    localparam logic [15:0] BPP_32 = 16'd32;

    typedef struct packed {
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] bpp;
        logic [15:0] hz;
        logic [15:0] pitch;
        logic [31:0] clk;
    } mode_t;

    typedef struct packed {
        logic write_entry;
        logic start;
        logic issue;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic more;
        logic pipe_busy;
        logic out_free;
    } dp_status_t;

    function automatic logic bpp_ok(input logic [15:0] bpp);
        return (bpp == BPP_8) || (bpp == BPP_16) || (bpp == BPP_24) || (bpp == BPP_32);
    endfunction

    // prod = width * bpp; a zero factor gives a zero product and so a zero pitch
    function automatic logic [15:0] min_pitch_of(input logic [31:0] prod);
        logic [29:0] raw;
        logic [30:0] al;
        raw = 30'(({1'b0, prod} + ROUND_BYTE) >> 3);
        al  = ({1'b0, raw} + ROUND_ALIGN) & ~ROUND_ALIGN;
        return (al > PITCH_LIMIT) ? 16'd0 : al[15:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/dmbf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmbf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dmbf_ram #(
    parameter int WIDTH = 112,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: rtl/dmbf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmbf_ctrl
// Sequencer: takes commands, drives the table scan, hands off the result.
// ----------------------------------------------------------------------------
module dmbf_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [1:0]            command,
    input  wire dmbf_pkg::dp_status_t  status,
    output logic                       in_ready,
    output dmbf_pkg::ctrl_cmd_t        ctl
);

    dmbf_pkg::state_t state_reg;
    dmbf_pkg::state_t state_next;
    logic             xfer;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dmbf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        in_ready        = 1'b0;
        xfer            = 1'b0;
        ctl.write_entry = 1'b0;
        ctl.start       = 1'b0;
        ctl.issue       = 1'b0;
        ctl.load_out    = 1'b0;
        case (state_reg)
            dmbf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                xfer     = in_valid;
                if (xfer)
                begin
                    if (command == dmbf_pkg::CMD_WRITE)
                    begin
                        ctl.write_entry = 1'b1;
                    end
                    else
                    begin
                        ctl.start  = 1'b1;
                        state_next = dmbf_pkg::ST_SCAN;
                    end
                end
            end
            dmbf_pkg::ST_SCAN:
            begin
                ctl.issue = status.more;
                if (!status.more)
                begin
                    state_next = dmbf_pkg::ST_DRAIN;
                end
            end
            dmbf_pkg::ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = dmbf_pkg::ST_RESULT;
                end
            end
            dmbf_pkg::ST_RESULT:
            begin
                if (status.out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = dmbf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dmbf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/dmbf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmbf_datapath
// Mode table, config registers, scan pipeline (read, multiply, evaluate)
// and output register.
// ----------------------------------------------------------------------------
module dmbf_datapath #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dmbf_pkg::ctrl_cmd_t  ctl,
    output dmbf_pkg::dp_status_t      status,
    input  wire logic                 cfg_valid,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic [1:0]           command,
    input  wire logic [3:0]           entry_index,
    input  wire logic [15:0]          width,
    input  wire logic [15:0]          height,
    input  wire logic [15:0]          bpp,
    input  wire logic [15:0]          refresh_rate,
    input  wire logic [15:0]          line_pitch,
    input  wire logic [31:0]          pixel_clock,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic                      found,
    output logic [3:0]                match_index,
    output logic [15:0]               min_pitch
);

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int MODE_W = $bits(dmbf_pkg::mode_t);

    // config
    logic [4:0]  entry_count_reg;
    logic [31:0] max_pclk_reg;

    // query context
    dmbf_pkg::mode_t query_reg;
    logic [1:0]      qcmd_reg;
    logic [CNT_W-1:0] limit_reg;
    logic [CNT_W-1:0] limit_next;
    logic [CNT_W-1:0] cnt_reg;

    // pipeline
    logic             s1_valid_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s2_valid_reg;
    logic [IDX_W-1:0] s2_idx_reg;
    dmbf_pkg::mode_t  s2_mode_reg;
    logic [31:0]      s2_prod_reg;

    // running result
    logic        hit_reg;
    logic        hit_next;
    logic [3:0]  res_idx_reg;
    logic [3:0]  res_idx_next;
    logic [15:0] res_pitch_reg;
    logic [15:0] res_pitch_next;
    logic [15:0] best_w_reg;
    logic [15:0] best_h_reg;
    logic [31:0] best_clk_reg;
    logic        take_best;

    // output register
    logic        out_valid_reg;
    logic        found_reg;
    logic [3:0]  match_index_reg;
    logic [15:0] min_pitch_reg;

    logic [MODE_W-1:0] ram_rdata;
    dmbf_pkg::mode_t   wr_mode;
    dmbf_pkg::mode_t   cand;
    logic              slot_ok;
    logic [15:0]       mp;
    logic              mode_ok;
    logic              base_ok;
    logic              better;

    assign wr_mode = '{w: width, h: height, bpp: bpp, hz: refresh_rate,
                       pitch: line_pitch, clk: pixel_clock};
    assign slot_ok = ({28'd0, entry_index} < 32'(TABLE_DEPTH));

    dmbf_ram #(
        .WIDTH (MODE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ctl.write_entry && slot_ok),
        .waddr (IDX_W'(entry_index)),
        .wdata (wr_mode),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            max_pclk_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == dmbf_pkg::CFG_ENTRY_COUNT)
            begin
                entry_count_reg <= cfg_data[4:0];
            end
            else if (cfg_index == dmbf_pkg::CFG_MAX_PCLK)
            begin
                max_pclk_reg <= cfg_data;
            end
        end
    end

    // validate runs a single pass with the query itself as candidate
    always_comb
    begin
        if (command == dmbf_pkg::CMD_VALIDATE)
        begin
            limit_next = CNT_W'(1);
        end
        else if ({27'd0, entry_count_reg} > 32'(TABLE_DEPTH))
        begin
            limit_next = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            limit_next = CNT_W'(entry_count_reg);
        end
    end

    assign cand = (qcmd_reg == dmbf_pkg::CMD_VALIDATE) ? query_reg
                                                        : dmbf_pkg::mode_t'(ram_rdata);

    // evaluate stage
    assign mp      = dmbf_pkg::min_pitch_of(s2_prod_reg);
    assign mode_ok = (s2_mode_reg.w != 16'd0) && (s2_mode_reg.h != 16'd0)
                  && dmbf_pkg::bpp_ok(s2_mode_reg.bpp) && (s2_mode_reg.hz != 16'd0)
                  && (s2_mode_reg.pitch >= mp) && (s2_mode_reg.clk != 32'd0)
                  && (s2_mode_reg.clk <= max_pclk_reg);
    assign base_ok = mode_ok && (s2_mode_reg.bpp == query_reg.bpp)
                  && ((query_reg.hz == 16'd0) || (s2_mode_reg.hz == query_reg.hz));
    assign better  = !hit_reg || (s2_mode_reg.w < best_w_reg)
                  || ((s2_mode_reg.w == best_w_reg) && (s2_mode_reg.h < best_h_reg))
                  || ((s2_mode_reg.w == best_w_reg) && (s2_mode_reg.h == best_h_reg)
                      && (s2_mode_reg.clk < best_clk_reg));

    always_comb
    begin
        hit_next       = hit_reg;
        res_idx_next   = res_idx_reg;
        res_pitch_next = res_pitch_reg;
        take_best      = 1'b0;
        if (ctl.start)
        begin
            hit_next       = 1'b0;
            res_idx_next   = 4'd0;
            res_pitch_next = 16'd0;
        end
        else if (s2_valid_reg)
        begin
            case (qcmd_reg)
                dmbf_pkg::CMD_VALIDATE:
                begin
                    hit_next       = mode_ok;
                    res_pitch_next = mp;
                end
                dmbf_pkg::CMD_FIND:
                begin
                    // first match wins
                    if (base_ok && !hit_reg && (s2_mode_reg.w == query_reg.w)
                        && (s2_mode_reg.h == query_reg.h))
                    begin
                        hit_next     = 1'b1;
                        res_idx_next = 4'(s2_idx_reg);
                    end
                end
                dmbf_pkg::CMD_BEST:
                begin
                    if (base_ok && (s2_mode_reg.w >= query_reg.w)
                        && (s2_mode_reg.h >= query_reg.h) && better)
                    begin
                        hit_next     = 1'b1;
                        res_idx_next = 4'(s2_idx_reg);
                        take_best    = 1'b1;
                    end
                end
                default:
                begin
                    hit_next = hit_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            limit_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.start)
            begin
                cnt_reg   <= '0;
                limit_reg <= limit_next;
            end
            else if (ctl.issue)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            s1_valid_reg <= ctl.issue;
            s2_valid_reg <= s1_valid_reg;
            hit_reg      <= hit_next;
            if (ctl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            query_reg <= wr_mode;
            qcmd_reg  <= command;
        end
        s1_idx_reg    <= cnt_reg[IDX_W-1:0];
        s2_idx_reg    <= s1_idx_reg;
        s2_mode_reg   <= cand;
        s2_prod_reg   <= {16'd0, cand.w} * {16'd0, cand.bpp};
        res_idx_reg   <= res_idx_next;
        res_pitch_reg <= res_pitch_next;
        if (take_best)
        begin
            best_w_reg   <= s2_mode_reg.w;
            best_h_reg   <= s2_mode_reg.h;
            best_clk_reg <= s2_mode_reg.clk;
        end
        if (ctl.load_out)
        begin
            found_reg       <= hit_reg;
            match_index_reg <= hit_reg ? res_idx_reg : 4'd0;
            min_pitch_reg   <= res_pitch_reg;
        end
    end

    assign status.more      = (cnt_reg < limit_reg);
    assign status.pipe_busy = s1_valid_reg || s2_valid_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign match_index = match_index_reg;
    assign min_pitch   = min_pitch_reg;

endmodule
`default_nettype wire

// File: rtl/display_mode_best_fit_search_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// display_mode_best_fit_search_top
// Display mode table with validate, exact search and best-fit search.
// ----------------------------------------------------------------------------
// Commands arrive on the in_* valid/ready channel. A write-entry command
// stores a mode in the table and returns nothing. Validate,
// find-exact and pick-best each return one result on the out_* channel.
// Config registers (0 entry_count, 1 max_pixel_clock) are written through the
// cfg_* channel, which is always ready; write them only while the block is idle.
// A search streams n = min(entry_count, TABLE_DEPTH) entries from the table RAM,
// one per cycle, through a read / multiply / evaluate pipeline (validate sends
// only the query itself); the next command is taken once the result has been
// loaded into the output register. The RAM read port and the single pitch
// multiplier limit the scan to one entry per cycle.
// Results sit in an output register: a stalled receiver holds the result and
// the block keeps working on the next command, stalling only when a new
// result is ready and the register is still full.
// Reset clears the config registers and control; table contents are
// undefined until written and must be written before they are searched.
// ----------------------------------------------------------------------------
module display_mode_best_fit_search_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [3:0]  entry_index,
    input  wire logic [15:0] width,
    input  wire logic [15:0] height,
    input  wire logic [15:0] bpp,
    input  wire logic [15:0] refresh_rate,
    input  wire logic [15:0] line_pitch,
    input  wire logic [31:0] pixel_clock,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             found,
    output logic [3:0]       match_index,
    output logic [15:0]      min_pitch
);

    dmbf_pkg::ctrl_cmd_t  ctl;
    dmbf_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    dmbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .status   (status),
        .in_ready (in_ready),
        .ctl      (ctl)
    );

    dmbf_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .command      (command),
        .entry_index  (entry_index),
        .width        (width),
        .height       (height),
        .bpp          (bpp),
        .refresh_rate (refresh_rate),
        .line_pitch   (line_pitch),
        .pixel_clock  (pixel_clock),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .found        (found),
        .match_index  (match_index),
        .min_pitch    (min_pitch)
    );

    // a result is never loaded over one still waiting for transfer
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_out |-> (!out_valid || out_ready))
        else $error("result loaded over a pending result");

    // no new command while the scan pipeline still holds entries
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !status.pipe_busy)
        else $error("command taken with scan pipeline busy");

    // reads stay within the scan limit
    a_issue_more: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.issue |-> status.more)
        else $error("table read past scan limit");

    // once a query starts, the input is no longer ready
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |=> !in_ready)
        else $error("input open right after query start");

endmodule
`default_nettype wire

// File: tb/sv/display_mode_best_fit_search_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_mode_best_fit_search_checker
// Watches the config, command and result channels of the mode table block.
// It keeps its own copy of the mode table and registers, predicts the answer
// to each accepted query and compares every result transfer, oldest first.
// ----------------------------------------------------------------------------
module display_mode_best_fit_search_checker #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [3:0]  entry_index,
    input  wire logic [15:0] width,
    input  wire logic [15:0] height,
    input  wire logic [15:0] bpp,
    input  wire logic [15:0] refresh_rate,
    input  wire logic [15:0] line_pitch,
    input  wire logic [31:0] pixel_clock,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic        found,
    input  wire logic [3:0]  match_index,
    input  wire logic [15:0] min_pitch,
    output int               fail_count,
    output int               pending_results
);
    import dmbf_pkg::*;

    typedef struct packed {
        logic        found;
        logic [3:0]  slot;
        logic [15:0] pitch;
    } answer_t;

    mode_t       table_copy [TABLE_DEPTH];
    logic [4:0]  scan_count = '0;
    logic [31:0] pclk_limit = '0;
    answer_t     owed_answers [$];
    int          bad_results = 0;

    // ceil(w*bpp/8) rounded up to 64 bytes; zero when it does not fit 16 bits
    function automatic logic [15:0] pitch_floor(input logic [15:0] w, input logic [15:0] b);
        logic [63:0] raw;
        logic [63:0] al;
        if (w == 16'd0 || b == 16'd0)
            return 16'd0;
        raw = (64'(w) * 64'(b) + 64'd7) / 64'd8;
        al  = (raw + 64'd63) & ~64'd63;
        return (al > 64'hFFFF) ? 16'd0 : al[15:0];
    endfunction

    function automatic logic mode_usable(input mode_t m);
        return m.w != 16'd0 && m.h != 16'd0 &&
               (m.bpp == BPP_8 || m.bpp == BPP_16 || m.bpp == BPP_24 || m.bpp == BPP_32) &&
               m.hz != 16'd0 && m.pitch >= pitch_floor(m.w, m.bpp) &&
               m.clk != 32'd0 && m.clk <= pclk_limit;
    endfunction

    function automatic answer_t answer_for(input cmd_t op, input mode_t q);
        answer_t    a;
        mode_t      m;
        mode_t      b;
        int         n;
        logic       hit;
        logic [3:0] pick;
        a    = '0;
        hit  = 1'b0;
        pick = 4'd0;
        if (op == CMD_VALIDATE)
        begin
            a.found = mode_usable(q);
            a.pitch = pitch_floor(q.w, q.bpp);
            return a;
        end
        n = (int'(scan_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(scan_count);
        for (int i = 0; i < n; i++)
        begin
            m = table_copy[i];
            if (mode_usable(m) && m.bpp == q.bpp && (q.hz == 16'd0 || m.hz == q.hz))
            begin
                if (op == CMD_FIND)
                begin
                    // first exact hit wins
                    if (!hit && m.w == q.w && m.h == q.h)
                    begin
                        hit  = 1'b1;
                        pick = 4'(i);
                    end
                end
                else if (m.w >= q.w && m.h >= q.h)
                begin
                    b = table_copy[pick];
                    // strict compare: an equal candidate keeps the earlier slot
                    if (!hit || m.w < b.w || (m.w == b.w && m.h < b.h) ||
                        (m.w == b.w && m.h == b.h && m.clk < b.clk))
                    begin
                        hit  = 1'b1;
                        pick = 4'(i);
                    end
                end
            end
        end
        a.found = hit;
        a.slot  = hit ? pick : 4'd0;
        return a;
    endfunction

    always @(posedge clk)
    begin : watch
        mode_t   req;
        answer_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_ENTRY_COUNT)
                    scan_count = cfg_data[4:0];
                else if (cfg_index == CFG_MAX_PCLK)
                    pclk_limit = cfg_data;
            end

            if (out_valid && out_ready)
            begin
                if (owed_answers.size() == 0)
                begin
                    if (bad_results < 10)
                        $display("%0t: unexpected result found=%0d slot=%0d pitch=%0d",
                                 $realtime, found, match_index, min_pitch);
                    bad_results++;
                end
                else
                begin
                    want = owed_answers.pop_front();
                    if (found !== want.found || match_index !== want.slot ||
                        min_pitch !== want.pitch)
                    begin
                        if (bad_results < 10)
                        begin
                            $write("%0t: result mismatch: expected found=%0d slot=%0d pitch=%0d",
                                   $realtime, want.found, want.slot, want.pitch);
                            $display(", got found=%0d slot=%0d pitch=%0d",
                                     found, match_index, min_pitch);
                        end
                        bad_results++;
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                req = {width, height, bpp, refresh_rate, line_pitch, pixel_clock};
                if (cmd_t'(command) == CMD_WRITE)
                begin
                    if (int'(entry_index) < TABLE_DEPTH)
                        table_copy[entry_index] = req;
                end
                else
                    owed_answers.push_back(answer_for(cmd_t'(command), req));
            end
        end
        fail_count      <= bad_results;
        pending_results <= owed_answers.size();
    end

endmodule

// File: tb/sv/display_mode_best_fit_search_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_mode_best_fit_search_top_tb
// Stimulus and verdict for the display mode table search block.
// A directed set loads a small table and covers validate, find and best-fit
// corner cases; then randomized phases change the registers between runs of
// mostly well-formed table writes and queries, with random idle cycles on
// both channels and one long result back-pressure stretch.
// ----------------------------------------------------------------------------
module display_mode_best_fit_search_top_tb;
    import dmbf_pkg::*;

    localparam int SETTLE_CYCLES      = 40;
    localparam int RESULT_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT     = 5000;
    localparam int PHASES             = 7;
    localparam int ITEMS_PER_PHASE    = 105;

    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        cfg_valid       = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index       = '0;
    logic [31:0] cfg_data        = '0;
    logic        in_valid        = 1'b0;
    logic        in_ready;
    logic [1:0]  command         = '0;
    logic [3:0]  entry_index     = '0;
    logic [15:0] width           = '0;
    logic [15:0] height          = '0;
    logic [15:0] bpp             = '0;
    logic [15:0] refresh_rate    = '0;
    logic [15:0] line_pitch      = '0;
    logic [31:0] pixel_clock     = '0;
    logic        out_valid;
    logic        out_ready       = 1'b0;
    logic        found;
    logic [3:0]  match_index;
    logic [15:0] min_pitch;

    int          fail_count;
    int          pending_results;

    int          in_idle_pct   = 20;
    int          out_stall_pct = 20;
    bit          hold_off_req  = 1'b0;
    logic [31:0] cur_pclk_max  = '0;
    mode_t       loaded_modes [16];
    int          quiet_cycles  = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    display_mode_best_fit_search_top #(.TABLE_DEPTH(16)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .entry_index(entry_index),
        .width(width), .height(height), .bpp(bpp), .refresh_rate(refresh_rate),
        .line_pitch(line_pitch), .pixel_clock(pixel_clock),
        .out_valid(out_valid), .out_ready(out_ready),
        .found(found), .match_index(match_index), .min_pitch(min_pitch)
    );

    display_mode_best_fit_search_checker #(.TABLE_DEPTH(16)) chk (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .entry_index(entry_index),
        .width(width), .height(height), .bpp(bpp), .refresh_rate(refresh_rate),
        .line_pitch(line_pitch), .pixel_clock(pixel_clock),
        .out_valid(out_valid), .out_ready(out_ready),
        .found(found), .match_index(match_index), .min_pitch(min_pitch),
        .fail_count(fail_count), .pending_results(pending_results)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic mode_t mk(input int w, input int h, input int b, input int hz,
                                 input int p, input int c);
        mode_t m;
        m.w     = 16'(w);
        m.h     = 16'(h);
        m.bpp   = 16'(b);
        m.hz    = 16'(hz);
        m.pitch = 16'(p);
        m.clk   = 32'(c);
        return m;
    endfunction

    // tightest legal pitch for a generated mode, saturated instead of wrapped
    function automatic logic [15:0] snug_pitch(input logic [15:0] w, input logic [15:0] b);
        longint bytes;
        bytes = ((longint'(w) * longint'(b) + 7) / 8 + 63) / 64 * 64;
        return (bytes > 65535) ? 16'hFFFF : 16'(bytes);
    endfunction

    // common resolutions so that exact hits and best-fit ties show up often
    function automatic mode_t make_mode();
        mode_t       m;
        logic [15:0] snug;
        logic [31:0] lim;
        int          r;
        case ($urandom_range(0, 6))
            0:       m.w = 16'd640;
            1:       m.w = 16'd800;
            2:       m.w = 16'd1024;
            3:       m.w = 16'd1280;
            4:       m.w = 16'd1920;
            5:       m.w = 16'd3840;
            default: m.w = 16'($urandom_range(1, 65535));
        endcase
        case ($urandom_range(0, 6))
            0:       m.h = 16'd480;
            1:       m.h = 16'd600;
            2:       m.h = 16'd768;
            3:       m.h = 16'd1024;
            4:       m.h = 16'd1080;
            5:       m.h = 16'd2160;
            default: m.h = 16'($urandom_range(1, 65535));
        endcase
        if ($urandom_range(0, 29) == 0)
            m.h = 16'd0;
        if ($urandom_range(0, 19) == 0)
            m.bpp = 16'($urandom_range(0, 65535));
        else
            m.bpp = 16'(8 * $urandom_range(1, 4));
        r = $urandom_range(0, 99);
        if (r < 45)
            m.hz = 16'd60;
        else if (r < 75)
            m.hz = 16'd75;
        else if (r < 95)
            m.hz = 16'($urandom_range(1, 65535));
        else
            m.hz = 16'd0;
        snug = snug_pitch(m.w, m.bpp);
        r = $urandom_range(0, 99);
        if (r < 50)
            m.pitch = snug;
        else if (r < 65)
            m.pitch = (snug > 16'hFFBF) ? 16'hFFFF : snug + 16'd64;
        else if (r < 75)
            m.pitch = (snug == 16'd0) ? 16'd0 : snug - 16'd1;
        else if (r < 90)
            m.pitch = 16'hFFFF;
        else
            m.pitch = 16'($urandom());
        lim = (cur_pclk_max == 32'd0) ? 32'd1 : cur_pclk_max;
        r = $urandom_range(0, 99);
        if (r < 70)
            m.clk = $urandom_range(1, lim);
        else if (r < 80)
            m.clk = cur_pclk_max;
        else if (r < 90)
            m.clk = cur_pclk_max + 32'd1;
        else
            m.clk = $urandom();
        return m;
    endfunction

    function automatic mode_t find_query();
        mode_t q;
        q = loaded_modes[$urandom_range(0, 15)];
        if ($urandom_range(0, 1) == 1)
            q.hz = 16'd0;
        if ($urandom_range(0, 9) == 0)
            q.w = q.w + 16'd1;
        q.pitch = 16'($urandom());
        q.clk   = $urandom();
        return q;
    endfunction

    function automatic mode_t fit_query();
        mode_t q;
        q = loaded_modes[$urandom_range(0, 15)];
        if ($urandom_range(0, 9) >= 3)
        begin
            q.w = 16'($urandom_range(0, q.w));
            q.h = 16'($urandom_range(0, q.h));
        end
        if ($urandom_range(0, 9) == 0)
            q.bpp = 16'(8 * $urandom_range(1, 4));
        if ($urandom_range(0, 1) == 1)
            q.hz = 16'd0;
        q.pitch = 16'($urandom());
        q.clk   = $urandom();
        return q;
    endfunction

    task automatic issue(input cmd_t c, input logic [3:0] slot, input mode_t m);
        int gap;
        gap = ($urandom_range(0, 99) < in_idle_pct) ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        command      <= c;
        entry_index  <= slot;
        width        <= m.w;
        height       <= m.h;
        bpp          <= m.bpp;
        refresh_rate <= m.hz;
        line_pitch   <= m.pitch;
        pixel_clock  <= m.clk;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic store_mode(input logic [3:0] slot, input mode_t m);
        issue(CMD_WRITE, slot, m);
        loaded_modes[slot] = m;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // drain all results, then leave room for a table write still in flight
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_results == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_item();
        mode_t      m;
        cmd_t       c;
        logic [3:0] slot;
        int         r;
        r    = $urandom_range(0, 99);
        slot = 4'($urandom_range(0, 15));
        if (r < 20)
            store_mode(slot, make_mode());
        else if (r < 40)
            issue(CMD_VALIDATE, slot, make_mode());
        else if (r < 65)
            issue(CMD_FIND, slot, find_query());
        else if (r < 90)
            issue(CMD_BEST, slot, fit_query());
        else
        begin
            m.w     = 16'($urandom());
            m.h     = 16'($urandom());
            m.bpp   = 16'($urandom());
            m.hz    = 16'($urandom());
            m.pitch = 16'($urandom());
            m.clk   = $urandom();
            c       = cmd_t'(2'($urandom_range(0, 3)));
            if (c == CMD_WRITE)
                store_mode(slot, m);
            else
                issue(c, slot, m);
        end
    endtask

    // result side: random stalls, plus one long hold on request
    initial
    begin : result_sink
        int stall_left;
        bit held;
        stall_left = 0;
        held       = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (RESULT_HOLD_CYCLES) @(negedge clk);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 99) < out_stall_pct)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("display_mode_best_fit_search_top verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int          cnt;
        logic [31:0] pmax;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_ENTRY_COUNT, 32'd8);
        write_reg(CFG_MAX_PCLK, 32'd200000);
        cur_pclk_max = 32'd200000;

        // small table: a size tie at 1024x768 broken by clock, a pitch just short, a duplicate of slot 2
        store_mode(4'd0, mk(1024, 768, 32, 60, 4096, 65000));
        store_mode(4'd1, mk(800, 600, 32, 60, 3200, 40000));
        store_mode(4'd2, mk(1280, 1024, 32, 60, 5120, 108000));
        store_mode(4'd3, mk(1024, 768, 32, 75, 4096, 78750));
        store_mode(4'd4, mk(1024, 768, 32, 60, 4096, 60000));
        store_mode(4'd5, mk(1024, 768, 32, 60, 4032, 30000));
        store_mode(4'd6, mk(1920, 1080, 16, 60, 3840, 148500));
        store_mode(4'd7, mk(1280, 1024, 32, 60, 5120, 108000));

        issue(CMD_VALIDATE, 4'd0, mk(1024, 768, 32, 60, 4096, 200000));
        issue(CMD_VALIDATE, 4'd0, mk(1024, 768, 32, 60, 4096, 200001));
        issue(CMD_VALIDATE, 4'd0, mk(0, 768, 32, 60, 4096, 1000));
        issue(CMD_VALIDATE, 4'd0, mk(1024, 768, 15, 60, 4096, 1000));
        // min pitch overflows to zero, so any pitch passes
        issue(CMD_VALIDATE, 4'd0, mk(65535, 1, 32, 1, 0, 1));
        issue(CMD_VALIDATE, 4'd0, mk(16368, 1, 32, 1, 65471, 1));
        issue(CMD_VALIDATE, 4'hF, mk(65535, 65535, 65535, 65535, 65535, 32'hFFFF_FFFF));
        issue(CMD_FIND, 4'd0, mk(1024, 768, 32, 0, 0, 0));
        issue(CMD_FIND, 4'd0, mk(1024, 768, 32, 75, 0, 0));
        issue(CMD_FIND, 4'd0, mk(640, 480, 32, 0, 0, 0));
        issue(CMD_BEST, 4'd0, mk(1000, 700, 32, 60, 0, 0));
        issue(CMD_BEST, 4'd0, mk(1100, 900, 32, 0, 0, 0));
        issue(CMD_BEST, 4'd0, mk(2000, 2000, 32, 0, 0, 0));
        issue(CMD_BEST, 4'd0, mk(0, 0, 16, 0, 0, 0));
        issue(CMD_BEST, 4'd0, mk(0, 0, 8, 0, 0, 0));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    cnt = 16; pmax = 32'hFFFF_FFFF; in_idle_pct = 30; out_stall_pct = 30;
                end
                1:
                begin
                    cnt = 31; pmax = 32'd250000; in_idle_pct = 0; out_stall_pct = 0;
                end
                2:
                begin
                    cnt = 0; pmax = $urandom(); in_idle_pct = 50; out_stall_pct = 50;
                end
                3:
                begin
                    cnt = 17; pmax = 32'd0; in_idle_pct = 20; out_stall_pct = 40;
                end
                4:
                begin
                    cnt = 5; pmax = 32'd150000; in_idle_pct = 70; out_stall_pct = 10;
                end
                5:
                begin
                    cnt = 16; pmax = $urandom(); in_idle_pct = 10; out_stall_pct = 60;
                end
                default:
                begin
                    cnt = 1; pmax = 32'd1; in_idle_pct = 40; out_stall_pct = 20;
                end
            endcase
            // upper data bits are junk; only the low five reach the count
            write_reg(CFG_ENTRY_COUNT, ($urandom() & 32'hFFFF_FFE0) | 32'(cnt));
            write_reg(CFG_MAX_PCLK, pmax);
            cur_pclk_max = pmax;
            // fill the rest of the table before any search can reach it
            if (ph == 0)
                for (int s = 8; s < 16; s++)
                    store_mode(4'(s), make_mode());
            if (ph == 1)
                hold_off_req = 1'b1;
            repeat (ITEMS_PER_PHASE) random_item();
        end

        settle();
        if (fail_count == 0 && pending_results == 0)
            $display("display_mode_best_fit_search_top verification clean");
        else
            $display("display_mode_best_fit_search_top verification failed");
        $finish;
    end

endmodule
